@@ rtl/acpu_pkg.sv @@
// Shared constants, types and codes for the accumulator CPU core.
package acpu_pkg;

  localparam int DATA_ADDR_BITS = 16;
  localparam int PC_BITS        = 24;
  localparam int WORD_BITS      = 32;

  localparam int MEM_WORDS   = 1 << DATA_ADDR_BITS;
  localparam int KEY_WORD    = 24576;
  localparam int CLEAR_WORDS = 24577;
  localparam int CLEAR_COUNT = (CLEAR_WORDS < MEM_WORDS) ? CLEAR_WORDS : MEM_WORDS;

  typedef logic [DATA_ADDR_BITS-1:0] addr_t;
  typedef logic [PC_BITS-1:0]        pc_t;
  typedef logic [WORD_BITS-1:0]      word_t;

  localparam addr_t KEY_INDEX  = addr_t'(KEY_WORD);
  localparam addr_t CLEAR_LAST = addr_t'(CLEAR_COUNT - 1);

  localparam logic [1:0] MODE_EXEC  = 2'd0;
  localparam logic [1:0] MODE_KEY   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    KIND_LOAD_A = 3'd0,
    KIND_ALU    = 3'd1,
    KIND_KEY    = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_NONE   = 3'd4
  } kind_t;

  typedef struct packed {
    logic sel_m;
    logic zx;
    logic nx;
    logic zy;
    logic ny;
    logic f_add;
    logic no;
    logic dst_a;
    logic dst_d;
    logic dst_m;
    logic j_lt;
    logic j_eq;
    logic j_gt;
  } ctrl_t;

  typedef struct packed {
    kind_t kind;
    ctrl_t ctrl;
    word_t word;
  } cmd_t;

  typedef struct packed {
    pc_t   next_pc;
    word_t a_value;
    word_t d_value;
    word_t alu_value;
    logic  jumped;
  } res_t;

endpackage

@@ rtl/acpu_front.sv @@
// Front end: takes a request, classifies it and holds the decoded command.
module acpu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [1:0]      mode,
  input  logic [31:0]     instruction,
  input  logic [31:0]     key_code,
  output logic            busy,
  output logic            cmd_push,
  output acpu_pkg::cmd_t  cmd,
  input  logic            cmd_full
);

  logic           held;
  acpu_pkg::cmd_t held_cmd;
  acpu_pkg::cmd_t decoded;

  always_comb begin
    decoded.kind  = acpu_pkg::KIND_NONE;
    decoded.word  = instruction;
    decoded.ctrl.sel_m = instruction[12];
    decoded.ctrl.zx    = instruction[11];
    decoded.ctrl.nx    = instruction[10];
    decoded.ctrl.zy    = instruction[9];
    decoded.ctrl.ny    = instruction[8];
    decoded.ctrl.f_add = instruction[7];
    decoded.ctrl.no    = instruction[6];
    decoded.ctrl.dst_a = instruction[5];
    decoded.ctrl.dst_d = instruction[4];
    decoded.ctrl.dst_m = instruction[3];
    decoded.ctrl.j_lt  = instruction[2];
    decoded.ctrl.j_eq  = instruction[1];
    decoded.ctrl.j_gt  = instruction[0];
    unique case (mode)
      acpu_pkg::MODE_EXEC: begin
        decoded.kind = instruction[31] ? acpu_pkg::KIND_ALU : acpu_pkg::KIND_LOAD_A;
      end
      acpu_pkg::MODE_KEY: begin
        decoded.kind = acpu_pkg::KIND_KEY;
        decoded.word = key_code;
      end
      acpu_pkg::MODE_CLEAR: begin
        decoded.kind = acpu_pkg::KIND_CLEAR;
      end
      default: begin
        decoded.kind = acpu_pkg::KIND_NONE;
      end
    endcase
  end

  assign cmd_push = held & !cmd_full;
  assign busy     = held & cmd_full;
  assign cmd      = held_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (cmd_push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_cmd <= decoded;
    end
  end

endmodule

@@ rtl/acpu_cmd_queue.sv @@
// Two-entry queue of decoded commands between front and back end.
module acpu_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  acpu_pkg::cmd_t  din,
  output logic            full,
  input  logic            pop,
  output acpu_pkg::cmd_t  dout,
  output logic            empty
);

  acpu_pkg::cmd_t slots [2];
  logic [1:0]     count;
  logic           wp;
  logic           rp;
  logic           do_push;
  logic           do_pop;

  assign full    = count[1];
  assign empty   = (count == 2'd0);
  assign dout    = slots[rp];
  assign do_push = push & !full;
  assign do_pop  = pop & !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_pop) rp <= !rp;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= din;
    end
  end

endmodule

@@ rtl/acpu_res_queue.sv @@
// Two-entry queue of finished results toward the output side.
module acpu_res_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  acpu_pkg::res_t  din,
  output logic            full,
  input  logic            pop,
  output acpu_pkg::res_t  dout,
  output logic            empty
);

  acpu_pkg::res_t slots [2];
  logic [1:0]     count;
  logic           wp;
  logic           rp;
  logic           do_push;
  logic           do_pop;

  assign full    = count[1];
  assign empty   = (count == 2'd0);
  assign dout    = slots[rp];
  assign do_push = push & !full;
  assign do_pop  = pop & !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_pop) rp <= !rp;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= din;
    end
  end

endmodule

@@ rtl/acpu_exec.sv @@
// Back end: registers, ALU, data memory and the memory clearing sweeps.
module acpu_exec (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_empty,
  input  acpu_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  input  logic            res_full,
  output logic            res_push,
  output acpu_pkg::res_t  res,
  output logic            init_busy
);

  typedef enum logic [3:0] {
    ST_INIT  = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_t;

  state_t          state;
  state_t          state_next;
  acpu_pkg::pc_t   pc;
  acpu_pkg::pc_t   pc_next;
  acpu_pkg::word_t reg_a;
  acpu_pkg::word_t reg_a_next;
  acpu_pkg::word_t reg_d;
  acpu_pkg::word_t reg_d_next;
  acpu_pkg::addr_t cnt;
  acpu_pkg::addr_t cnt_next;
  acpu_pkg::cmd_t  cur;

  acpu_pkg::word_t dmem [acpu_pkg::MEM_WORDS];
  acpu_pkg::word_t rdata;
  logic            we;
  acpu_pkg::addr_t waddr;
  acpu_pkg::word_t wdata;
  acpu_pkg::addr_t a_index;

  acpu_pkg::word_t x_op;
  acpu_pkg::word_t y_op;
  acpu_pkg::word_t alu;
  acpu_pkg::word_t new_a;
  acpu_pkg::word_t new_d;
  logic            neg16;
  logic            zero16;
  logic            pos16;
  logic            take_jump;
  acpu_pkg::pc_t   pc_inc;

  assign a_index   = reg_a[acpu_pkg::DATA_ADDR_BITS-1:0];
  assign cmd_pop   = (state == ST_IDLE) & !cmd_empty & !res_full;
  assign init_busy = (state == ST_INIT);
  assign pc_inc    = pc + acpu_pkg::pc_t'(1);

  // ALU on the command latched at the start of the instruction
  always_comb begin
    x_op = reg_d;
    y_op = cur.ctrl.sel_m ? rdata : reg_a;
    if (cur.ctrl.zx) x_op = '0;
    if (cur.ctrl.nx) x_op = ~x_op;
    if (cur.ctrl.zy) y_op = '0;
    if (cur.ctrl.ny) y_op = ~y_op;
    alu = cur.ctrl.f_add ? (x_op + y_op) : (x_op & y_op);
    if (cur.ctrl.no) alu = ~alu;
    new_a     = cur.ctrl.dst_a ? alu : reg_a;
    new_d     = cur.ctrl.dst_d ? alu : reg_d;
    neg16     = alu[15];
    zero16    = (alu[15:0] == 16'd0);
    pos16     = !neg16 & !zero16;
    take_jump = (cur.ctrl.j_lt & neg16) | (cur.ctrl.j_eq & zero16) |
                (cur.ctrl.j_gt & pos16);
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    reg_a_next = reg_a;
    reg_d_next = reg_d;
    cnt_next   = cnt;
    we         = 1'b0;
    waddr      = cnt;
    wdata      = '0;
    res_push   = 1'b0;
    res.next_pc   = pc;
    res.a_value   = reg_a;
    res.d_value   = reg_d;
    res.alu_value = '0;
    res.jumped    = 1'b0;
    unique case (state)
      ST_INIT: begin
        we       = 1'b1;
        cnt_next = cnt + acpu_pkg::addr_t'(1);
        if (&cnt) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_pop) begin
          unique case (cmd.kind)
            acpu_pkg::KIND_LOAD_A: begin
              pc_next     = pc_inc;
              reg_a_next  = cmd.word;
              res_push    = 1'b1;
              res.next_pc = pc_inc;
              res.a_value = cmd.word;
            end
            acpu_pkg::KIND_ALU: begin
              state_next = ST_EXEC;
            end
            acpu_pkg::KIND_KEY: begin
              we       = 1'b1;
              waddr    = acpu_pkg::KEY_INDEX;
              wdata    = cmd.word;
              res_push = 1'b1;
            end
            acpu_pkg::KIND_CLEAR: begin
              pc_next    = '0;
              cnt_next   = '0;
              state_next = ST_CLEAR;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      ST_EXEC: begin
        we         = cur.ctrl.dst_m;
        waddr      = a_index;
        wdata      = alu;
        reg_a_next = new_a;
        reg_d_next = new_d;
        pc_next    = take_jump ? new_a[acpu_pkg::PC_BITS-1:0] : pc_inc;
        res_push      = 1'b1;
        res.next_pc   = pc_next;
        res.a_value   = new_a;
        res.d_value   = new_d;
        res.alu_value = alu;
        res.jumped    = take_jump;
        state_next    = ST_IDLE;
      end
      ST_CLEAR: begin
        we       = 1'b1;
        cnt_next = cnt + acpu_pkg::addr_t'(1);
        if (cnt == acpu_pkg::CLEAR_LAST) begin
          res_push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      pc    <= '0;
      reg_a <= '0;
      reg_d <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      reg_a <= reg_a_next;
      reg_d <= reg_d_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
  end

  // read at A every cycle into a register; the ALU state consumes it in the following cycle
  always_ff @(posedge clk) begin
    if (we) begin
      dmem[waddr] <= wdata;
    end
    rdata <= dmem[a_index];
  end

  a_onehot_state: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("back end state not one-hot");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC |=> state == ST_IDLE)
    else $error("ALU instruction did not finish in one cycle");

  a_jump_target: assert property (@(posedge clk) disable iff (rst)
    res_push && res.jumped |-> res.next_pc == res.a_value[acpu_pkg::PC_BITS-1:0])
    else $error("jump target differs from A");

  a_init_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_INIT && !(&cnt) |=> state == ST_INIT)
    else $error("startup clear left early");

endmodule

@@ rtl/accumulator_cpu_core_32bit_unit.sv @@
// A request (load A, key, idle code, ALU instruction or clear) is held in the front end,
// then passes the command queue, the back end and the result queue to the result ports.
// The back end finishes a load-A or key request as it pops it; an ALU instruction takes a
// registered data memory read, then ALU and write back; a clear zeroes words 0 to 24576.
// Reset: synchronous; pc, A and D go to zero, then full stays high while the back end
// writes zero through every data memory word.
module accumulator_cpu_core_32bit_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          mode,
  input  logic [31:0]                         instruction,
  input  logic signed [31:0]                  key_code,
  output logic                                empty,
  input  logic                                pop,
  output logic [acpu_pkg::PC_BITS-1:0]        next_pc,
  output logic signed [31:0]                  a_value,
  output logic signed [31:0]                  d_value,
  output logic signed [31:0]                  alu_value,
  output logic                                jumped
);

  logic           front_busy;
  logic           init_busy;
  logic           take;
  logic           cmd_push;
  logic           cmd_full;
  logic           cmd_empty;
  logic           cmd_pop;
  acpu_pkg::cmd_t front_cmd;
  acpu_pkg::cmd_t queued_cmd;
  logic           res_push;
  logic           res_full;
  acpu_pkg::res_t exec_res;
  acpu_pkg::res_t out_res;

  assign full = front_busy | init_busy;
  assign take = push & !full;

  acpu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .mode        (mode),
    .instruction (instruction),
    .key_code    (key_code),
    .busy        (front_busy),
    .cmd_push    (cmd_push),
    .cmd         (front_cmd),
    .cmd_full    (cmd_full)
  );

  acpu_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (front_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (queued_cmd),
    .empty (cmd_empty)
  );

  acpu_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (queued_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (exec_res),
    .init_busy (init_busy)
  );

  acpu_res_queue u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (exec_res),
    .full  (res_full),
    .pop   (pop),
    .dout  (out_res),
    .empty (empty)
  );

  assign next_pc   = out_res.next_pc;
  assign a_value   = out_res.a_value;
  assign d_value   = out_res.d_value;
  assign alu_value = out_res.alu_value;
  assign jumped    = out_res.jumped;

endmodule
